[rtl/core/utf8_caseless_substring_match_macros.svh]
// Assertion macros shared by the caseless UTF-8 substring matcher.
`ifndef UTF8_CASELESS_SUBSTRING_MATCH_MACROS_SVH
`define UTF8_CASELESS_SUBSTRING_MATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UCSM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucsm check failed");

// Next-cycle implication, disabled while reset is high.
`define UCSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ucsm check failed");

`endif

[rtl/core/ucsm_pkg.sv]
// Shared types, constants and the case folding function of the matcher.
package ucsm_pkg;

  localparam int POINT_W = 21;
  localparam int BYTE_W  = 8;

  typedef logic [POINT_W-1:0] point_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  // Folding ranges.
  localparam point_t UPPER_A      = 21'h000041;
  localparam point_t UPPER_Z      = 21'h00005A;
  localparam point_t CYR_FIRST    = 21'h000410;
  localparam point_t CYR_LAST     = 21'h00042F;
  localparam point_t CYR_IO_UPPER = 21'h000401;
  localparam point_t CYR_IO_LOWER = 21'h000451;
  localparam point_t CASE_OFFSET  = 21'h000020;

  // Control from the decode sequencer to the cell row and result logic.
  typedef struct packed {
    logic   emit;          // a code point is on the stream this cycle
    logic   to_hay;        // 1: haystack point, 0: needle point
    point_t point;         // folded code point
    logic   clear_hay;     // clear partial matches and the found flag
    logic   new_needle;    // start an empty needle
    logic   close_needle;  // the needle is complete
    logic   finish;        // haystack done, capture the result
  } ucsm_ctl_t;

  // Lower-case fold of one code point.
  function automatic point_t lower_point(input point_t c);
    point_t r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_OFFSET;
    end else if (c >= CYR_FIRST && c <= CYR_LAST) begin
      r = c + CASE_OFFSET;
    end else if (c == CYR_IO_UPPER) begin
      r = CYR_IO_LOWER;
    end
    return r;
  endfunction

endpackage

[rtl/core/ucsm_seq.sv]
// Request sequencer and UTF-8 decoder that emits at most one folded code point per cycle.
module ucsm_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                op,
  input  ucsm_pkg::byte_t     data_byte,
  input  logic                has_byte,
  input  logic                last,
  input  logic                needle_open,
  output logic                busy,
  output ucsm_pkg::ucsm_ctl_t ctl
);
  import ucsm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BYTE  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // What follows once the held bytes are flushed.
  localparam logic [1:0] AFT_CLOSE = 2'd0;
  localparam logic [1:0] AFT_BYTE  = 2'd1;
  localparam logic [1:0] AFT_LAST  = 2'd2;

  localparam byte_t CONT_MASK  = 8'hC0;
  localparam byte_t CONT_CODE  = 8'h80;
  localparam byte_t LEAD2_MASK = 8'hE0;
  localparam byte_t LEAD2_CODE = 8'hC0;
  localparam byte_t LEAD3_MASK = 8'hF0;
  localparam byte_t LEAD3_CODE = 8'hE0;
  localparam byte_t LEAD4_MASK = 8'hF8;
  localparam byte_t LEAD4_CODE = 8'hF0;

  logic [1:0] state, state_next;
  logic [1:0] after, after_next;
  logic       lat_op, lat_has, lat_last;
  byte_t      lat_byte;
  byte_t      pend [3];
  byte_t      pend_next [3];
  logic [1:0] pcount, pcount_next;
  logic [1:0] ecount, ecount_next;
  logic [1:0] fidx, fidx_next;
  point_t     raw_point;
  point_t     assembled;
  byte_t      flush_byte;
  logic       is_cont;

  assign busy    = (state != ST_IDLE);
  assign is_cont = ((lat_byte & CONT_MASK) == CONT_CODE);

  // Code point from the held lead and continuation bytes plus the current byte.
  always_comb begin
    unique case (ecount)
      2'd1:    assembled = {10'd0, pend[0][4:0], lat_byte[5:0]};
      2'd2:    assembled = {5'd0, pend[0][3:0], pend[1][5:0], lat_byte[5:0]};
      2'd3:    assembled = {pend[0][2:0], pend[1][5:0], pend[2][5:0], lat_byte[5:0]};
      default: assembled = '0;
    endcase
  end

  // Held byte selected by the flush index.
  always_comb begin
    unique case (fidx)
      2'd0:    flush_byte = pend[0];
      2'd1:    flush_byte = pend[1];
      default: flush_byte = pend[2];
    endcase
  end

  // Sequencer: one decode step per cycle.
  always_comb begin
    state_next  = state;
    after_next  = after;
    pend_next   = pend;
    pcount_next = pcount;
    ecount_next = ecount;
    fidx_next   = fidx;
    raw_point   = '0;
    ctl         = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          // A needle request with no open needle starts a fresh one.
          if (!op && !needle_open) begin
            ctl.new_needle = 1'b1;
            ctl.clear_hay  = 1'b1;
            pcount_next    = 2'd0;
            ecount_next    = 2'd0;
          end
          if (op && (has_byte || last) && needle_open) begin
            state_next = ST_FLUSH;
            after_next = AFT_CLOSE;
            fidx_next  = 2'd0;
          end else if (!(op && !has_byte && !last)) begin
            state_next = ST_BYTE;
          end
        end
      end

      ST_BYTE: begin
        state_next = lat_last ? ST_FLUSH : ST_IDLE;
        after_next = AFT_LAST;
        fidx_next  = 2'd0;
        if (lat_has) begin
          if (pcount != 2'd0) begin
            if (is_cont) begin
              if (pcount >= ecount) begin
                ctl.emit    = 1'b1;
                raw_point   = assembled;
                pcount_next = 2'd0;
                ecount_next = 2'd0;
              end else begin
                pend_next[pcount] = lat_byte;
                pcount_next       = pcount + 2'd1;
              end
            end else begin
              // Broken sequence: give the held bytes, then decode this byte again.
              state_next = ST_FLUSH;
              after_next = AFT_BYTE;
            end
          end else begin
            if (lat_byte[7] == 1'b0) begin
              ctl.emit  = 1'b1;
              raw_point = {13'd0, lat_byte};
            end else if ((lat_byte & LEAD2_MASK) == LEAD2_CODE) begin
              pend_next[0] = lat_byte;
              pcount_next  = 2'd1;
              ecount_next  = 2'd1;
            end else if ((lat_byte & LEAD3_MASK) == LEAD3_CODE) begin
              pend_next[0] = lat_byte;
              pcount_next  = 2'd1;
              ecount_next  = 2'd2;
            end else if ((lat_byte & LEAD4_MASK) == LEAD4_CODE) begin
              pend_next[0] = lat_byte;
              pcount_next  = 2'd1;
              ecount_next  = 2'd3;
            end else begin
              // Stray continuation or invalid lead stands as a raw point.
              ctl.emit  = 1'b1;
              raw_point = {13'd0, lat_byte};
            end
          end
        end
      end

      ST_FLUSH: begin
        if (fidx < pcount) begin
          ctl.emit  = 1'b1;
          raw_point = {13'd0, flush_byte};
          fidx_next = fidx + 2'd1;
        end else begin
          pcount_next = 2'd0;
          ecount_next = 2'd0;
          unique case (after)
            AFT_CLOSE: begin
              ctl.close_needle = 1'b1;
              ctl.clear_hay    = 1'b1;
              state_next       = ST_BYTE;
            end
            AFT_BYTE: begin
              state_next = ST_BYTE;
            end
            AFT_LAST: begin
              if (lat_op) begin
                ctl.finish = 1'b1;
              end else begin
                ctl.close_needle = 1'b1;
              end
              ctl.clear_hay = 1'b1;
              state_next    = ST_IDLE;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    ctl.to_hay = (state == ST_FLUSH && after == AFT_CLOSE) ? 1'b0 : lat_op;
    ctl.point  = lower_point(raw_point);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      after  <= AFT_LAST;
      pcount <= 2'd0;
      ecount <= 2'd0;
      fidx   <= 2'd0;
    end else begin
      state  <= state_next;
      after  <= after_next;
      pcount <= pcount_next;
      ecount <= ecount_next;
      fidx   <= fidx_next;
    end
  end

  // Latched request and held bytes.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      lat_op   <= op;
      lat_byte <= data_byte;
      lat_has  <= has_byte;
      lat_last <= last;
    end
    pend <= pend_next;
  end

endmodule

[rtl/core/ucsm_cell.sv]
// One needle position: stored code point and its shift-and match bit.
module ucsm_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             wr_en,
  input  logic             hay_en,
  input  logic             active,
  input  ucsm_pkg::point_t point,
  input  logic             link_in,
  output logic             link_out
);
  import ucsm_pkg::*;

  point_t needle_point;
  logic   pm;

  assign link_out = pm;

  // Needle code point store.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      needle_point <= point;
    end
  end

  // Match bit: the needle up to here ends at the latest haystack point.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pm <= 1'b0;
    end else if (hay_en) begin
      pm <= active && link_in && (needle_point == point);
    end
  end

endmodule

[rtl/core/utf8_caseless_substring_match.sv]
// Top level of the caseless UTF-8 substring matcher.
//
//  Channel   Direction  Handshake               Payload
//  request   in         start & !busy           op, data_byte, has_byte, last
//  result    out        done (one-cycle strobe) match, needle_overflow
//
// A well-formed byte is accepted in the idle state, then decoded in the byte state.
// Held bytes given back at a string end or on closing a needle are emitted in order in the
// flush state; a broken sequence then decodes the current byte again in the byte state.
// The decoder sets the rate: at most one code point per cycle, no new request while busy.
// Reset is synchronous on rst and leaves an empty, closed needle.
// The result strobe is never stalled; a new request may be accepted while it shows.
module utf8_caseless_substring_match #(
  parameter int MAX_NEEDLE_POINTS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            op,
  input  ucsm_pkg::byte_t data_byte,
  input  logic            has_byte,
  input  logic            last,
  output logic            done,
  output logic            match,
  output logic            needle_overflow
);
  import ucsm_pkg::*;
  `include "utf8_caseless_substring_match_macros.svh"

  localparam int LEN_W = $clog2(MAX_NEEDLE_POINTS + 1);

  ucsm_ctl_t                    ctl;
  logic [LEN_W-1:0]             len;
  logic                         too_long;
  logic                         needle_open;
  logic                         found;
  logic                         hay_en;
  logic                         hit;
  logic                         len_full;
  logic [MAX_NEEDLE_POINTS-1:0] pm_vec;
  logic [MAX_NEEDLE_POINTS-1:0] active_vec;
  logic [MAX_NEEDLE_POINTS-1:0] last_vec;

  // Decoder and request sequencer.
  ucsm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .op          (op),
    .data_byte   (data_byte),
    .has_byte    (has_byte),
    .last        (last),
    .needle_open (needle_open),
    .busy        (busy),
    .ctl         (ctl)
  );

  assign len_full = (len == LEN_W'(MAX_NEEDLE_POINTS));
  assign hay_en   = ctl.emit && ctl.to_hay && !too_long && (len != '0);

  // Row of match cells; each passes its match bit to the next position.
  for (genvar i = 0; i < MAX_NEEDLE_POINTS; i++) begin : g_cell
    logic link_in;
    if (i == 0) begin : g_head
      assign link_in = 1'b1;
    end else begin : g_body
      assign link_in = pm_vec[i-1];
    end
    assign active_vec[i] = (len > LEN_W'(i));
    assign last_vec[i]   = (len == LEN_W'(i + 1));

    ucsm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (ctl.clear_hay),
      .wr_en    (ctl.emit && !ctl.to_hay && (len == LEN_W'(i))),
      .hay_en   (hay_en),
      .active   (active_vec[i]),
      .point    (ctl.point),
      .link_in  (link_in),
      .link_out (pm_vec[i])
    );
  end

  // The whole needle ends at the latest haystack point.
  assign hit = |(pm_vec & last_vec);

  // Needle bookkeeping and found flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      len         <= '0;
      too_long    <= 1'b0;
      needle_open <= 1'b0;
      found       <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.new_needle) begin
        len         <= '0;
        too_long    <= 1'b0;
        needle_open <= 1'b1;
      end else if (ctl.emit && !ctl.to_hay) begin
        if (len_full) begin
          too_long <= 1'b1;
        end else begin
          len <= len + LEN_W'(1);
        end
      end
      if (ctl.close_needle) begin
        needle_open <= 1'b0;
      end
      found <= ctl.clear_hay ? 1'b0 : (found || hit);
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      match           <= !too_long && ((len == '0) || found || hit);
      needle_overflow <= too_long;
    end
  end

  `UCSM_ASSERT_NOW(a_overflow_no_match, clk, rst, done && needle_overflow, !match)
  `UCSM_ASSERT_NOW(a_done_after_work, clk, rst, done, $past(busy))
  `UCSM_ASSERT_NEXT(a_needle_grows, clk, rst,
      ctl.emit && !ctl.to_hay && !ctl.new_needle && !len_full,
      len == $past(len) + LEN_W'(1))
  `UCSM_ASSERT_NOW(a_no_match_past_end, clk, rst, 1'b1, (pm_vec & ~active_vec) == '0)

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the caseless UTF-8 substring matcher.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ucsm_pkg::*;

  localparam int NEEDLE_MAX    = 32;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 600;

  // One expected haystack verdict.
  typedef struct packed {
    logic found;
    logic overflow;
  } verdict_t;

  // Predicts the verdict of each finished haystack and checks the block against it.
  class caseless_search_sb;
    point_t                needle_pts[NEEDLE_MAX];
    int                    needle_len;
    bit                    needle_is_open;
    bit                    needle_too_big;
    byte_t                 held[3];
    int                    held_count;
    int                    cont_needed;
    logic [NEEDLE_MAX-1:0] run_bits;
    bit                    hit;
    verdict_t              verdicts[$];
    int                    failures;

    function new();
      foreach (needle_pts[i]) needle_pts[i] = '0;
      needle_len     = 0;
      needle_is_open = 0;
      needle_too_big = 0;
      failures       = 0;
      clear_decoder();
      clear_progress();
    endfunction

    function void clear_decoder();
      foreach (held[i]) held[i] = '0;
      held_count  = 0;
      cont_needed = 0;
    endfunction

    function void clear_progress();
      run_bits = '0;
      hit      = 0;
    endfunction

    function int waiting();
      return verdicts.size();
    endfunction

    // Lower-case fold: ASCII capitals, Cyrillic capitals and the capital IO.
    function point_t fold_case(point_t c);
      if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h410 && c <= 21'h42F)) begin
        return c + 21'h20;
      end
      if (c == 21'h401) begin
        return 21'h451;
      end
      return c;
    endfunction

    // Append a code point to the needle, or advance the shift-and scan.
    function void put_point(bit to_hay, logic [31:0] raw);
      point_t c;
      int     i;
      c = fold_case(raw[POINT_W-1:0]);
      if (!to_hay) begin
        if (needle_len < NEEDLE_MAX) begin
          needle_pts[needle_len] = c;
          needle_len++;
        end else begin
          needle_too_big = 1;
        end
        return;
      end
      if (needle_too_big || needle_len == 0) begin
        return;
      end
      for (i = needle_len - 1; i > 0; i--) begin
        run_bits[i] = run_bits[i-1] && (needle_pts[i] == c);
      end
      run_bits[0] = (needle_pts[0] == c);
      if (run_bits[needle_len-1]) begin
        hit = 1;
      end
    endfunction

    // Held bytes of an unfinished sequence come out as raw code points.
    function void flush_held(bit to_hay);
      int i;
      for (i = 0; i < held_count; i++) begin
        put_point(to_hay, {24'd0, held[i]});
      end
      clear_decoder();
    endfunction

    function void take_byte(bit to_hay, byte_t b);
      logic [31:0] acc;
      int          i;
      if (held_count != 0) begin
        if (b[7:6] == 2'b10) begin
          if (held_count >= cont_needed) begin
            case (cont_needed)
              1: acc = {24'd0, held[0] & 8'h1F};
              2: acc = {24'd0, held[0] & 8'h0F};
              default: acc = {24'd0, held[0] & 8'h07};
            endcase
            for (i = 1; i < held_count; i++) begin
              acc = (acc << 6) | {26'd0, held[i][5:0]};
            end
            acc = (acc << 6) | {26'd0, b[5:0]};
            clear_decoder();
            put_point(to_hay, acc);
          end else begin
            held[held_count] = b;
            held_count++;
          end
          return;
        end
        flush_held(to_hay);
      end
      if (b < 8'h80) begin
        put_point(to_hay, {24'd0, b});
        return;
      end
      if (b[7:5] == 3'b110) begin
        cont_needed = 1;
      end else if (b[7:4] == 4'b1110) begin
        cont_needed = 2;
      end else if (b[7:3] == 5'b11110) begin
        cont_needed = 3;
      end else begin
        put_point(to_hay, {24'd0, b});
        return;
      end
      held[0]    = b;
      held_count = 1;
    endfunction

    function void close_needle();
      flush_held(0);
      needle_is_open = 0;
      clear_progress();
    endfunction

    // Update the prediction with one accepted request.
    function void note_request(logic o, byte_t b, logic has, logic fin);
      verdict_t v;
      if (o == 1'b0) begin
        if (!needle_is_open) begin
          needle_len     = 0;
          needle_too_big = 0;
          needle_is_open = 1;
          clear_decoder();
          clear_progress();
        end
        if (has) take_byte(0, b);
        if (fin) close_needle();
        return;
      end
      if (!has && !fin) begin
        return;
      end
      if (needle_is_open) close_needle();
      if (has) take_byte(1, b);
      if (!fin) begin
        return;
      end
      flush_held(1);
      v.overflow = needle_too_big;
      v.found    = needle_too_big ? 1'b0 : (needle_len == 0 ? 1'b1 : hit);
      verdicts.push_back(v);
      clear_progress();
    endfunction

    // Compare one result with the oldest pending verdict.
    function void check_result(logic got_match, logic got_overflow);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("unexpected result: match %0b needle_overflow %0b", got_match, got_overflow);
        failures++;
        return;
      end
      v = verdicts.pop_front();
      if (got_match !== v.found) begin
        $error("match: expected %0b, got %0b", v.found, got_match);
        failures++;
      end
      if (got_overflow !== v.overflow) begin
        $error("needle_overflow: expected %0b, got %0b", v.overflow, got_overflow);
        failures++;
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  logic  op;
  byte_t data_byte;
  logic  has_byte;
  logic  last;
  logic  done;
  logic  match;
  logic  needle_overflow;

  caseless_search_sb sb;
  int                sender_idle_pct;
  int                requests_sent;
  byte_t             text_buf[$];

  utf8_caseless_substring_match #(
    .MAX_NEEDLE_POINTS(NEEDLE_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .last(last),
    .done(done),
    .match(match),
    .needle_overflow(needle_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #5_000_000;
    $display("[utf8_caseless_substring_match] ERROR");
    $finish;
  end

  // Watch both handshakes; results are checked before the request of the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(match, needle_overflow);
      if (start && !busy) sb.note_request(op, data_byte, has_byte, last);
    end
  end

  // Offer one request, idling first at random, and hold it until it is taken.
  task automatic send_request(input logic o, input byte_t b, input logic h, input logic l);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    start     <= 1'b1;
    op        <= o;
    data_byte <= b;
    has_byte  <= h;
    last      <= l;
    do @(posedge clk); while (busy);
    if (h || l) requests_sent++;
  endtask

  // Stop sending until every verdict has come back, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send a byte string. Ending 0 marks last on the final byte, 1 adds an empty
  // closing request, 2 leaves the string open.
  task automatic send_string(input logic o, input byte_t s[$], input int ending);
    int i;
    for (i = 0; i < s.size(); i++) begin
      if ($urandom_range(99) < 3) send_request(o, byte_t'($urandom_range(255)), 1'b0, 1'b0);
      send_request(o, s[i], 1'b1, (ending == 0) && (i == s.size() - 1));
    end
    if (ending == 1 || (ending == 0 && s.size() == 0)) begin
      send_request(o, byte_t'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  // Encode a code point into text_buf, sometimes in an overlong form.
  function automatic void append_utf8(point_t p);
    int n;
    if (p < 21'h80) n = 1;
    else if (p < 21'h800) n = 2;
    else if (p < 21'h10000) n = 3;
    else n = 4;
    if ($urandom_range(99) < 10) n = $urandom_range(4, n);
    case (n)
      1: text_buf.push_back({1'b0, p[6:0]});
      2: begin
        text_buf.push_back({3'b110, p[10:6]});
        text_buf.push_back({2'b10, p[5:0]});
      end
      3: begin
        text_buf.push_back({4'b1110, p[15:12]});
        text_buf.push_back({2'b10, p[11:6]});
        text_buf.push_back({2'b10, p[5:0]});
      end
      default: begin
        text_buf.push_back({5'b11110, p[20:18]});
        text_buf.push_back({2'b10, p[17:12]});
        text_buf.push_back({2'b10, p[11:6]});
        text_buf.push_back({2'b10, p[5:0]});
      end
    endcase
  endfunction

  // Half the time a small caseful alphabet so that runs match; otherwise fold boundaries or anything.
  function automatic point_t pick_point();
    case ($urandom_range(23))
      0, 1:   return 21'h61;
      2, 3:   return 21'h41;
      4, 5:   return 21'h62;
      6:      return 21'h42;
      7, 8:   return 21'h430;
      9:      return 21'h410;
      10:     return 21'h451;
      11:     return 21'h401;
      12:     return 21'h40;
      13:     return 21'h5A;
      14:     return 21'h5B;
      15:     return 21'h40F;
      16:     return 21'h42F;
      17:     return 21'h44F;
      18:     return 21'h400;
      19:     return 21'h0;
      20:     return point_t'($urandom_range(127));
      21:     return point_t'($urandom_range(21'h7FF));
      default: return point_t'($urandom_range(21'h1FFFFF));
    endcase
  endfunction

  // Flip the case of a foldable point at random.
  function automatic point_t vary_case(point_t p);
    if ($urandom_range(1) == 0) return p;
    if ((p >= 21'h61 && p <= 21'h7A) || (p >= 21'h430 && p <= 21'h44F)) return p - CASE_OFFSET;
    if ((p >= UPPER_A && p <= UPPER_Z) || (p >= CYR_FIRST && p <= CYR_LAST)) return p + CASE_OFFSET;
    if (p == CYR_IO_LOWER) return CYR_IO_UPPER;
    if (p == CYR_IO_UPPER) return CYR_IO_LOWER;
    return p;
  endfunction

  // One random episode: a needle with haystacks, a noise string, or loose requests.
  task automatic run_episode();
    point_t needle_q[$];
    int     kind;
    int     n;
    int     pos;
    int     i;
    kind = $urandom_range(99);
    if (kind < 70) begin
      case ($urandom_range(99)) inside
        [0:4]:   n = 0;
        [5:79]:  n = $urandom_range(1, 4);
        [80:91]: n = $urandom_range(5, 12);
        default: n = $urandom_range(NEEDLE_MAX - 4, NEEDLE_MAX + 4);
      endcase
      for (i = 0; i < n; i++) needle_q.push_back(pick_point());
      text_buf = {};
      foreach (needle_q[j]) append_utf8(needle_q[j]);
      send_string(1'b0, text_buf, $urandom_range(2));
      repeat ($urandom_range(1, 4)) begin
        text_buf = {};
        n = $urandom_range(10);
        pos = ($urandom_range(99) < 60) ? $urandom_range(n) : -1;
        for (i = 0; i <= n; i++) begin
          if (i == pos) begin
            foreach (needle_q[j]) append_utf8(vary_case(needle_q[j]));
          end
          if (i < n) begin
            if ($urandom_range(99) < 5) text_buf.push_back(byte_t'($urandom_range(255, 128)));
            else append_utf8(pick_point());
          end
        end
        send_string(1'b1, text_buf, $urandom_range(1));
      end
    end else if (kind < 85) begin
      // Raw bytes biased toward lead and continuation values.
      text_buf = {};
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(3) == 0) text_buf.push_back(byte_t'($urandom_range(255)));
        else text_buf.push_back(byte_t'($urandom_range(255, 128)));
      end
      send_string(1'($urandom_range(1)), text_buf, $urandom_range(1));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_request(1'($urandom_range(1)), byte_t'($urandom_range(255)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    sb = new();
    requests_sent   = 0;
    sender_idle_pct = 35;
    rst       <= 1'b1;
    start     <= 1'b0;
    op        <= 1'b0;
    data_byte <= '0;
    has_byte  <= 1'b0;
    last      <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: haystack with no needle given at all.
    send_request(1'b1, 8'h41, 1'b1, 1'b1);
    // Caseless ASCII needle and haystack, then an empty haystack.
    send_request(1'b0, 8'h41, 1'b1, 1'b0);
    send_request(1'b0, 8'h62, 1'b1, 1'b1);
    send_request(1'b1, 8'h78, 1'b1, 1'b0);
    send_request(1'b1, 8'h61, 1'b1, 1'b0);
    send_request(1'b1, 8'h42, 1'b1, 1'b1);
    send_request(1'b1, 8'h00, 1'b0, 1'b1);
    // Capital IO as needle, closed implicitly by the haystack, small io in the haystack.
    send_request(1'b0, 8'hD0, 1'b1, 1'b0);
    send_request(1'b0, 8'h81, 1'b1, 1'b0);
    send_request(1'b1, 8'hD1, 1'b1, 1'b0);
    send_request(1'b1, 8'h91, 1'b1, 1'b1);
    // Broken two-byte sequence in needle and haystack, then stray bytes.
    send_request(1'b0, 8'hC3, 1'b1, 1'b0);
    send_request(1'b0, 8'h41, 1'b1, 1'b1);
    send_request(1'b1, 8'hC3, 1'b1, 1'b0);
    send_request(1'b1, 8'h61, 1'b1, 1'b1);
    send_request(1'b1, 8'hFF, 1'b1, 1'b0);
    send_request(1'b1, 8'h80, 1'b1, 1'b1);
    // Sequence truncated at the end of both strings.
    send_request(1'b0, 8'hF0, 1'b1, 1'b0);
    send_request(1'b0, 8'h9F, 1'b1, 1'b1);
    send_request(1'b1, 8'hF0, 1'b1, 1'b0);
    send_request(1'b1, 8'h9F, 1'b1, 1'b1);
    // Empty needle opened by an idle request, an ignored haystack request, empty haystack.
    send_request(1'b0, 8'h00, 1'b0, 1'b0);
    send_request(1'b1, 8'hFF, 1'b0, 1'b0);
    send_request(1'b1, 8'h00, 1'b0, 1'b1);
    // Overlong capital A as needle, zero byte in the haystack.
    send_request(1'b0, 8'hC1, 1'b1, 1'b0);
    send_request(1'b0, 8'h81, 1'b1, 1'b1);
    send_request(1'b1, 8'h00, 1'b1, 1'b0);
    send_request(1'b1, 8'h61, 1'b1, 1'b1);
    drain();

    // Random phases: busy sender, mostly idle sender, then back to back.
    while (requests_sent < PHASE_ITEMS) run_episode();
    drain();
    sender_idle_pct = 88;
    while (requests_sent < 2 * PHASE_ITEMS) run_episode();
    drain();
    sender_idle_pct = 0;
    while (requests_sent < 3 * PHASE_ITEMS) run_episode();
    drain();

    if (sb.failures == 0 && sb.waiting() == 0) begin
      $display("[utf8_caseless_substring_match] OK");
    end else begin
      $display("[utf8_caseless_substring_match] ERROR");
    end
    $finish;
  end

endmodule
